>>> rtl/tmdd_pkg.sv
// ============================================================================
// tmdd_pkg
// Types and constants shared by the toroidal 2-D minimum-distance decoder.
// ============================================================================
`default_nettype none

package tmdd_pkg;

    localparam int COORD_BITS = 16;
    localparam int Q_W        = 14;
    localparam int ALPHA_W    = 13;
    localparam int BETA_W     = 12;
    localparam int T_W        = 14;
    localparam int C_W        = 15;
    localparam int D_W        = 18;
    localparam int A_W        = 16;
    localparam int DIST_W     = 33;
    localparam int BEST_W     = 28;
    localparam int IDX_W      = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_ALPHA   = 2'd1;
    localparam logic [1:0] REG_BETA    = 2'd2;
    localparam logic [1:0] REG_LARGE   = 2'd3;

    localparam logic [Q_W-1:0]     MODULUS_RST = 14'd1024;
    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 13'd512;
    localparam logic [BETA_W-1:0]  BETA_RST    = 12'd0;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rx_x0;
        logic signed [COORD_BITS-1:0] rx_x1;
    } t_rx_beat;

    typedef struct packed {
        logic [IDX_W-1:0] best_index;
        logic             not_found;
    } t_dec_beat;

    typedef struct packed {
        logic [Q_W-1:0]     q;
        logic [ALPHA_W-1:0] alpha;
        logic [BETA_W-1:0]  beta;
        logic               large_cb;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] m0;
        logic [COORD_BITS-1:0] m1;
        logic                  n0;
        logic                  n1;
    } t_mod_beat;

    typedef struct packed {
        logic [T_W-1:0]    t0;
        logic [T_W-1:0]    t1;
        logic [BEST_W-1:0] best;
        logic [IDX_W-1:0]  idx;
        logic              found;
    } t_dist_beat;

endpackage

`default_nettype wire

>>> rtl/tmdd_mod_cell.sv
// ============================================================================
// tmdd_mod_cell
// One restoring step of the mod-q reduction: subtract q shifted left by SHIFT
// from both magnitudes where it fits.
// ============================================================================
`default_nettype none

module tmdd_mod_cell #(
    parameter int SHIFT = 0
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_adv,
    input  wire [tmdd_pkg::Q_W-1:0]    i_q,
    input  wire                        i_valid,
    input  tmdd_pkg::t_mod_beat        i_beat,
    output logic                       o_valid,
    output tmdd_pkg::t_mod_beat        o_beat
);
    localparam int W = tmdd_pkg::COORD_BITS + tmdd_pkg::Q_W;

    logic [W-1:0]         w_qs;
    logic [W-1:0]         w_e0;
    logic [W-1:0]         w_e1;
    tmdd_pkg::t_mod_beat  n_beat;
    logic                 r_valid;
    tmdd_pkg::t_mod_beat  r_beat;

    always_comb begin
        w_qs   = {{tmdd_pkg::COORD_BITS{1'b0}}, i_q} << SHIFT;
        w_e0   = {{tmdd_pkg::Q_W{1'b0}}, i_beat.m0};
        w_e1   = {{tmdd_pkg::Q_W{1'b0}}, i_beat.m1};
        n_beat = i_beat;
        if (w_e0 >= w_qs) begin
            n_beat.m0 = w_e0[tmdd_pkg::COORD_BITS-1:0] - w_qs[tmdd_pkg::COORD_BITS-1:0];
        end
        if (w_e1 >= w_qs) begin
            n_beat.m1 = w_e1[tmdd_pkg::COORD_BITS-1:0] - w_qs[tmdd_pkg::COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

>>> rtl/tmdd_cw_cell.sv
// ============================================================================
// tmdd_cw_cell
// One codeword of the search: torus distance to codeword INDEX over two
// stages, then keep it when strictly below the best so far (cells from index 4 up only with the large codebook).
// ============================================================================
`default_nettype none

module tmdd_cw_cell #(
    parameter int INDEX = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  tmdd_pkg::t_cfg       i_cfg,
    input  wire                  i_valid,
    input  tmdd_pkg::t_dist_beat i_beat,
    output logic                 o_valid,
    output tmdd_pkg::t_dist_beat o_beat
);
    localparam int D_W = tmdd_pkg::D_W;
    localparam int A_W = tmdd_pkg::A_W;
    localparam logic [tmdd_pkg::IDX_W-1:0] IDX = tmdd_pkg::IDX_W'(INDEX);

    logic [tmdd_pkg::C_W-1:0]  w_h;
    logic [tmdd_pkg::C_W-1:0]  w_a;
    logic [tmdd_pkg::C_W-1:0]  w_b;
    logic [tmdd_pkg::C_W-1:0]  w_bx;
    logic [tmdd_pkg::C_W-1:0]  w_by;
    logic [tmdd_pkg::C_W-1:0]  w_cx;
    logic [tmdd_pkg::C_W-1:0]  w_cy;
    logic [A_W-1:0]            n_ax;
    logic [A_W-1:0]            n_ay;
    logic                      w_active;
    logic [tmdd_pkg::DIST_W-1:0] w_d;
    tmdd_pkg::t_dist_beat      n_beat;

    logic                      r_valid_a;
    tmdd_pkg::t_dist_beat      r_beat_a;
    logic [A_W-1:0]            r_ax;
    logic [A_W-1:0]            r_ay;
    logic                      r_valid_b;
    tmdd_pkg::t_dist_beat      r_beat_b;

    function automatic logic [A_W-1:0] axis_min(
        input logic [tmdd_pkg::T_W-1:0] t,
        input logic [tmdd_pkg::Q_W-1:0] q,
        input logic [tmdd_pkg::C_W-1:0] c
    );
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] dm;
        logic signed [D_W-1:0] dp;
        logic [A_W-1:0]        a0;
        logic [A_W-1:0]        am;
        logic [A_W-1:0]        ap;
        logic [A_W-1:0]        m;
        d0 = $signed({4'b0, t}) - $signed({3'b0, c});
        dm = d0 - $signed({4'b0, q});
        dp = d0 + $signed({4'b0, q});
        a0 = d0[D_W-1] ? A_W'(-d0) : A_W'(d0);
        am = dm[D_W-1] ? A_W'(-dm) : A_W'(dm);
        ap = dp[D_W-1] ? A_W'(-dp) : A_W'(dp);
        m  = (am < a0) ? am : a0;
        m  = (ap < m) ? ap : m;
        return m;
    endfunction

    always_comb begin
        w_h = {2'b0, i_cfg.q[tmdd_pkg::Q_W-1:1]};
        w_a = {2'b0, i_cfg.alpha};
        w_b = {3'b0, i_cfg.beta};
        unique case (INDEX % 4)
            0: begin
                w_bx = '0;
                w_by = '0;
            end
            1: begin
                w_bx = w_b;
                w_by = w_a;
            end
            2: begin
                w_bx = w_a;
                w_by = w_b;
            end
            default: begin
                w_bx = w_a + w_b;
                w_by = w_a + w_b;
            end
        endcase
        w_cx = w_bx + ((((INDEX / 4) % 2) == 1) ? w_h : '0);
        w_cy = w_by + ((((INDEX / 8) % 2) == 1) ? w_h : '0);
        n_ax = axis_min(i_beat.t0, i_cfg.q, w_cx);
        n_ay = axis_min(i_beat.t1, i_cfg.q, w_cy);
    end

    always_comb begin
        w_active = (INDEX < 4) || i_cfg.large_cb;
        w_d      = {17'b0, r_ax} * {17'b0, r_ax} + {17'b0, r_ay} * {17'b0, r_ay};
        n_beat   = r_beat_a;
        if (w_active && (w_d < tmdd_pkg::DIST_W'(r_beat_a.best))) begin
            n_beat.best  = tmdd_pkg::BEST_W'(w_d);
            n_beat.idx   = IDX;
            n_beat.found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_adv) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat_a <= i_beat;
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_beat_b <= n_beat;
        end
    end

    assign o_valid = r_valid_b;
    assign o_beat  = r_beat_b;

endmodule

`default_nettype wire

>>> rtl/toroidal_2d_min_distance_decoder.sv
// ============================================================================
// toroidal_2d_min_distance_decoder
// Nearest-codeword decoder for 2-D points on a mod-q torus.
// ============================================================================
// Accepts one point per cycle while no result is stalled and returns one decision per point, in order.
// The pipeline is an input register, one restoring cell per coordinate
// bit for the mod-q reduction, a fold stage that finishes the remainder and
// seeds the bound q*q, then two stages per codeword cell. The whole pipeline
// holds while a result is stalled.
// Configure only while the pipeline is empty.
`default_nettype none

module toroidal_2d_min_distance_decoder #(
    parameter int MAX_CODEWORDS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [tmdd_pkg::ADDR_W-1:0]     paddr,
    input  wire [tmdd_pkg::DATA_W-1:0]     pwdata,
    output logic [tmdd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  tmdd_pkg::t_rx_beat             i_rx,
    output logic                           o_valid,
    input  wire                            i_stall,
    output tmdd_pkg::t_dec_beat            o_dec
);
    localparam int CB = tmdd_pkg::COORD_BITS;

    tmdd_pkg::t_cfg        r_cfg;
    logic                  w_adv;
    logic                  w_wr;

    logic                  r_in_valid;
    tmdd_pkg::t_mod_beat   r_in;
    tmdd_pkg::t_mod_beat   n_in;

    logic                  w_mod_v [0:CB];
    tmdd_pkg::t_mod_beat   w_mod   [0:CB];

    logic                  r_fold_valid;
    tmdd_pkg::t_dist_beat  r_fold;
    tmdd_pkg::t_dist_beat  n_fold;

    logic                  w_cw_v [0:MAX_CODEWORDS];
    tmdd_pkg::t_dist_beat  w_cw   [0:MAX_CODEWORDS];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.q        <= tmdd_pkg::MODULUS_RST;
            r_cfg.alpha    <= tmdd_pkg::ALPHA_RST;
            r_cfg.beta     <= tmdd_pkg::BETA_RST;
            r_cfg.large_cb <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                tmdd_pkg::REG_MODULUS: r_cfg.q        <= pwdata[tmdd_pkg::Q_W-1:0];
                tmdd_pkg::REG_ALPHA:   r_cfg.alpha    <= pwdata[tmdd_pkg::ALPHA_W-1:0];
                tmdd_pkg::REG_BETA:    r_cfg.beta     <= pwdata[tmdd_pkg::BETA_W-1:0];
                tmdd_pkg::REG_LARGE:   r_cfg.large_cb <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tmdd_pkg::REG_MODULUS: prdata = {18'b0, r_cfg.q};
            tmdd_pkg::REG_ALPHA:   prdata = {19'b0, r_cfg.alpha};
            tmdd_pkg::REG_BETA:    prdata = {20'b0, r_cfg.beta};
            tmdd_pkg::REG_LARGE:   prdata = {31'b0, r_cfg.large_cb};
        endcase
    end

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    always_comb begin
        n_in.n0 = i_rx.rx_x0[CB-1];
        n_in.n1 = i_rx.rx_x1[CB-1];
        n_in.m0 = n_in.n0 ? (~i_rx.rx_x0 + 1'b1) : i_rx.rx_x0;
        n_in.m1 = n_in.n1 ? (~i_rx.rx_x1 + 1'b1) : i_rx.rx_x1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_fold_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid   <= i_valid;
            r_fold_valid <= w_mod_v[CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in   <= n_in;
            r_fold <= n_fold;
        end
    end

    assign w_mod_v[0] = r_in_valid;
    assign w_mod[0]   = r_in;

    for (genvar k = 0; k < CB; k++) begin : g_mod
        tmdd_mod_cell #(
            .SHIFT (CB - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_q     (r_cfg.q),
            .i_valid (w_mod_v[k]),
            .i_beat  (w_mod[k]),
            .o_valid (w_mod_v[k+1]),
            .o_beat  (w_mod[k+1])
        );
    end

    always_comb begin
        n_fold.best  = {14'b0, r_cfg.q} * {14'b0, r_cfg.q};
        n_fold.idx   = '0;
        n_fold.found = 1'b0;
        if (r_cfg.q == '0) begin
            n_fold.t0 = '0;
            n_fold.t1 = '0;
        end else begin
            n_fold.t0 = (w_mod[CB].n0 && (w_mod[CB].m0 != '0))
                ? tmdd_pkg::T_W'(r_cfg.q - w_mod[CB].m0[tmdd_pkg::Q_W-1:0])
                : tmdd_pkg::T_W'(w_mod[CB].m0);
            n_fold.t1 = (w_mod[CB].n1 && (w_mod[CB].m1 != '0))
                ? tmdd_pkg::T_W'(r_cfg.q - w_mod[CB].m1[tmdd_pkg::Q_W-1:0])
                : tmdd_pkg::T_W'(w_mod[CB].m1);
        end
    end

    assign w_cw_v[0] = r_fold_valid;
    assign w_cw[0]   = r_fold;

    for (genvar i = 0; i < MAX_CODEWORDS; i++) begin : g_cw
        tmdd_cw_cell #(
            .INDEX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cfg   (r_cfg),
            .i_valid (w_cw_v[i]),
            .i_beat  (w_cw[i]),
            .o_valid (w_cw_v[i+1]),
            .o_beat  (w_cw[i+1])
        );
    end

    assign o_valid          = w_cw_v[MAX_CODEWORDS];
    assign o_dec.best_index = w_cw[MAX_CODEWORDS].found ? w_cw[MAX_CODEWORDS].idx : '0;
    assign o_dec.not_found  = !w_cw[MAX_CODEWORDS].found;

endmodule

`default_nettype wire

>>> rtl/tmdd_checker.sv
// ============================================================================
// tmdd_checker
// Port-level checks for the toroidal 2-D minimum-distance decoder.
// ============================================================================
`default_nettype none

module tmdd_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  o_stall,
    input  wire                  o_valid,
    input  wire                  i_stall,
    input  tmdd_pkg::t_dec_beat  o_dec,
    input  wire                  pready
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dec))
        else $error("stalled result beat changed");

    a_stall_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not track a held result");

    a_none_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dec.not_found |-> o_dec.best_index == '0)
        else $error("index set on a not-found result");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind toroidal_2d_min_distance_decoder tmdd_checker u_tmdd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_dec   (o_dec),
    .pready  (pready)
);

`default_nettype wire
